>>> rtl/core/twbc_pkg.sv
package twbc_pkg;

  localparam int unsigned Rounds = 11;
  localparam int unsigned StageCnt = Rounds + 2;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t w2;
    word_t w1;
    word_t w0;
  } blk_t;

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_MID  = 2'd1,
    REG_KEY_HIGH = 2'd2
  } reg_idx_e;

  function automatic word_t rotl(word_t v, int unsigned n);
    word_t r;
    r = (v << n) | (v >> (32 - n));
    return r;
  endfunction

  function automatic word_t bitrev(word_t v);
    word_t r;
    for (int i = 0; i < 32; i++) r[i] = v[31 - i];
    return r;
  endfunction

  function automatic word_t theta_w(word_t x, word_t y, word_t z);
    word_t r;
    r = x ^ (x >> 16) ^ (y << 16) ^ (y >> 16) ^ (z << 16) ^ (y >> 24)
        ^ (z << 8) ^ (z >> 8) ^ (x << 24) ^ (z >> 16) ^ (x << 16)
        ^ (z >> 24) ^ (x << 8);
    return r;
  endfunction

  function automatic blk_t theta(blk_t a);
    blk_t r;
    r.w0 = theta_w(a.w0, a.w1, a.w2);
    r.w1 = theta_w(a.w1, a.w2, a.w0);
    r.w2 = theta_w(a.w2, a.w0, a.w1);
    return r;
  endfunction

  function automatic blk_t mu(blk_t a);
    blk_t r;
    r.w0 = bitrev(a.w2);
    r.w1 = bitrev(a.w1);
    r.w2 = bitrev(a.w0);
    return r;
  endfunction

  function automatic blk_t round_f(blk_t a, blk_t k);
    blk_t t;
    blk_t g;
    t = theta(a ^ k);
    t.w0 = rotl(t.w0, 22);
    t.w2 = rotl(t.w2, 1);
    g.w0 = ~t.w0 ^ (~t.w1 & t.w2);
    g.w1 = ~t.w1 ^ (~t.w2 & t.w0);
    g.w2 = ~t.w2 ^ (~t.w0 & t.w1);
    g.w0 = rotl(g.w0, 1);
    g.w2 = rotl(g.w2, 22);
    return g;
  endfunction

endpackage

>>> rtl/core/twbc_stage.sv
module twbc_stage import twbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  logic kind_i,
  input  blk_t blk_i,
  output logic valid_o,
  output logic kind_o,
  output blk_t blk_o,
  input  blk_t key_i
);

  logic valid_q;
  logic kind_q;
  blk_t blk_q;

  // one round per stage; hold when the pipe stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_q <= kind_i;
      blk_q  <= round_f(blk_i, key_i);
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign blk_o   = blk_q;

endmodule

>>> rtl/core/three_word_block_cipher_top.sv
// Three-word block cipher, fully unrolled round pipeline.
// Channels:
//   s_axis_*: input items; tdata holds in_word0..2, tuser holds kind
//             (0 encrypt, 1 decrypt).
//   m_axis_*: result items; tdata holds out_word0..2.
//   cfg_*   : key register writes (index 0 key_low, 1 key_mid, 2 key_high);
//             other indexes are dropped. Write only while the block is idle.
// Stages: one input register stage (mu for decrypt items), eleven round
// stages, one output stage (final key add, theta, mu for decrypt items).
// Throughput: one item per cycle while the receiver does not stall; each
// round has its own stage register.
// The decrypt key mu(theta(key)) is held in a register updated on writes.
// Stall: the whole pipe advances only when the output register is empty or
// taken, so a stalled receiver holds every item in place; nothing is lost.
// Reset: clears all valid bits and the key to zero.
module three_word_block_cipher_top import twbc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // in_word0, in_word1, in_word2
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // out_word0, out_word1, out_word2
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  blk_t key_q, dkey_q, key_d;
  logic adv;

  assign cfg_ready = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_d.w0 = cfg_data;
        REG_KEY_MID:  key_d.w1 = cfg_data;
        REG_KEY_HIGH: key_d.w2 = cfg_data;
        default:      key_d = key_q;
      endcase
    end
  end

  // hold encrypt key and its decrypt form side by side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      dkey_q <= '0;
    end else begin
      key_q  <= key_d;
      dkey_q <= mu(theta(key_d));
    end
  end

  // advance the pipe when the output slot is free or being taken
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic v_s [StageCnt-1];
  logic k_s [StageCnt-1];
  blk_t b_s [StageCnt-1];
  blk_t in_blk;
  logic v_in_q;
  logic k_in_q;
  blk_t b_in_q;
  logic v_out_q;
  blk_t b_out_q;

  assign in_blk = s_axis_tdata;

  // entry stage: apply mu for decrypt items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q <= 1'b0;
    end else if (adv) begin
      v_in_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_in_q <= s_axis_tuser;
      b_in_q <= s_axis_tuser ? mu(in_blk) : in_blk;
    end
  end

  assign v_s[0] = v_in_q;
  assign k_s[0] = k_in_q;
  assign b_s[0] = b_in_q;

  for (genvar r = 0; r < Rounds; r++) begin : g_rnd
    twbc_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (v_s[r]),
      .kind_i  (k_s[r]),
      .blk_i   (b_s[r]),
      .valid_o (v_s[r+1]),
      .kind_o  (k_s[r+1]),
      .blk_o   (b_s[r+1]),
      .key_i   (k_s[r] ? dkey_q : key_q)
    );
  end

  // output stage: final key add and theta, undo mu for decrypt
  blk_t fin, res;
  assign fin = theta(b_s[Rounds] ^ (k_s[Rounds] ? dkey_q : key_q));
  assign res = k_s[Rounds] ? mu(fin) : fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (adv) begin
      v_out_q <= v_s[Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_out_q <= res;
    end
  end

  assign m_axis_tvalid = v_out_q;
  assign m_axis_tdata  = b_out_q;

endmodule
